FILE: hw/rtl/adsr_pkg.sv
// types, constants, microcode table and helpers of the adsr envelope generator
package adsr_pkg;

   localparam int LEN_W      = 24;
   localparam int FRAC_W     = 16;
   localparam int LEVEL_W    = FRAC_W + 1;
   localparam int NUM_W      = LEN_W + LEVEL_W;
   localparam int QUO_W      = LEVEL_W;
   localparam int CNT_W      = $clog2(QUO_W);
   localparam int USED_W     = LEN_W + 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [LEVEL_W-1:0] GAIN_ONE = LEVEL_W'(1) << FRAC_W;

   localparam logic [LEN_W-1:0]   ATTACK_RESET  = LEN_W'(441);
   localparam logic [LEN_W-1:0]   DECAY_RESET   = LEN_W'(4410);
   localparam logic [LEN_W-1:0]   RELEASE_RESET = LEN_W'(8820);
   localparam logic [LEVEL_W-1:0] SUSTAIN_RESET = LEVEL_W'(45875);

   typedef enum logic [1:0] {
      REG_ATTACK  = 2'd0,
      REG_DECAY   = 2'd1,
      REG_RELEASE = 2'd2,
      REG_SUSTAIN = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      SEG_ATTACK  = 3'd0,
      SEG_DECAY   = 3'd1,
      SEG_SUSTAIN = 3'd2,
      SEG_RELEASE = 3'd3,
      SEG_IDLE    = 3'd4
   } seg_type;

   typedef enum logic [3:0] {
      STEP_WAIT     = 4'd0,
      STEP_DECODE   = 4'd1,
      STEP_START_A  = 4'd2,
      STEP_START_B  = 4'd3,
      STEP_SKIP     = 4'd4,
      STEP_CHECK    = 4'd5,
      STEP_SUS_BR   = 4'd6,
      STEP_MUL_NUM  = 4'd7,
      STEP_DIV_INIT = 4'd8,
      STEP_DIV      = 4'd9,
      STEP_ENV      = 4'd10,
      STEP_MUL_GAIN = 4'd11,
      STEP_EMIT     = 4'd12
   } step_type;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_REQ,
      HOLD_RSP
   } hold_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_START_A,
      OP_START_B,
      OP_SKIP,
      OP_CHECK,
      OP_MUL_NUM,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_ENV,
      OP_MUL_GAIN,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_TICK,
      JMP_LEN_ZERO,
      JMP_SEG_DONE,
      JMP_NOTE_END,
      JMP_SUSTAIN,
      JMP_COUNT
   } jump_type;

   typedef struct packed {
      hold_type hold;
      op_type   op;
      jump_type jump;
      step_type target;
   } ucode_type;

   // control store: one word per step
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      case (step)
         STEP_WAIT:     word = '{HOLD_REQ,  OP_ACCEPT,   JMP_NEXT,     STEP_WAIT};
         STEP_DECODE:   word = '{HOLD_NONE, OP_NONE,     JMP_TICK,     STEP_SKIP};
         STEP_START_A:  word = '{HOLD_NONE, OP_START_A,  JMP_LEN_ZERO, STEP_WAIT};
         STEP_START_B:  word = '{HOLD_NONE, OP_START_B,  JMP_NEXT,     STEP_WAIT};
         STEP_SKIP:     word = '{HOLD_NONE, OP_SKIP,     JMP_SEG_DONE, STEP_SKIP};
         STEP_CHECK:    word = '{HOLD_NONE, OP_CHECK,    JMP_NOTE_END, STEP_WAIT};
         STEP_SUS_BR:   word = '{HOLD_NONE, OP_NONE,     JMP_SUSTAIN,  STEP_ENV};
         STEP_MUL_NUM:  word = '{HOLD_NONE, OP_MUL_NUM,  JMP_NEXT,     STEP_WAIT};
         STEP_DIV_INIT: word = '{HOLD_NONE, OP_DIV_INIT, JMP_NEXT,     STEP_WAIT};
         STEP_DIV:      word = '{HOLD_NONE, OP_DIV_STEP, JMP_COUNT,    STEP_DIV};
         STEP_ENV:      word = '{HOLD_NONE, OP_ENV,      JMP_NEXT,     STEP_WAIT};
         STEP_MUL_GAIN: word = '{HOLD_NONE, OP_MUL_GAIN, JMP_NEXT,     STEP_WAIT};
         STEP_EMIT:     word = '{HOLD_RSP,  OP_EMIT,     JMP_ALWAYS,   STEP_WAIT};
         default:       word = '{HOLD_NONE, OP_NONE,     JMP_ALWAYS,   STEP_WAIT};
      endcase
      return word;
   endfunction

   // clamp a level to full scale
   function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] value);
      return (value > GAIN_ONE) ? GAIN_ONE : value;
   endfunction

endpackage

FILE: hw/rtl/adsr_envelope_generator.sv
// linear adsr envelope generator: microcoded sequencer, shared multiplier and serial divider
//
// Linear ADSR envelope for one note at a time. A start transfer (action 1) loads the note
// length and velocity and produces the first gain sample; each tick transfer (action 0)
// produces the next sample until the note length is used up, the final one flagged by
// last. A tick while no note plays, or a start with zero length, produces no result.
// Segments run attack, decay, sustain, release, skipping those of zero length; the
// sustain length is note length minus the other three, floored at zero, and is latched
// at start, while the other lengths and the sustain level are read live. Gain is Q.16
// (65536 = 1.0); levels above 1.0 are clamped. Registers at byte address 0 attack,
// 4 decay, 8 release, 12 sustain level. A sample in attack, decay or release is computed by
// the 17-step restoring divider, which a sustain sample skips; a start also runs the start
// steps, and the skip step repeats for every skipped segment. A new request is taken once
// the sequencer is back at its wait step, even while the previous result still sits in the
// output register.
module adsr_envelope_generator
   import adsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic [LEN_W-1:0]      req_note_length,
   input  logic [LEVEL_W-1:0]    req_note_velocity,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [LEVEL_W-1:0]    rsp_gain,
   output logic [1:0]            rsp_segment,
   output logic                  rsp_last,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // configuration registers
   logic [LEN_W-1:0]   attack_ff,  attack_in;
   logic [LEN_W-1:0]   decay_ff,   decay_in;
   logic [LEN_W-1:0]   release_ff, release_in;
   logic [LEVEL_W-1:0] sustain_ff, sustain_in;

   // sequencer
   step_type  pc_ff, pc_in;
   ucode_type uword;
   logic      hold;
   logic      jump_taken;

   // latched request
   logic               action_ff,   action_in;
   logic [LEN_W-1:0]   note_len_ff, note_len_in;
   logic [LEVEL_W-1:0] note_vel_ff, note_vel_in;

   // note state
   seg_type            seg_ff,  seg_in;
   logic [LEN_W-1:0]   pos_ff,  pos_in;
   logic [LEN_W-1:0]   left_ff, left_in;
   logic [LEVEL_W-1:0] vel_ff,  vel_in;
   logic [LEN_W-1:0]   sus_ff,  sus_in;
   logic [USED_W-1:0]  used_ff, used_in;

   // arithmetic datapath
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [LEN_W-1:0]   div_ff, div_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [LEVEL_W-1:0] env_ff, env_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_gain_ff,  rsp_gain_in;
   logic [1:0]         rsp_seg_ff,   rsp_seg_in;
   logic               rsp_last_ff,  rsp_last_in;

   // shared decode signals
   logic [LEN_W-1:0]   seg_len;
   logic               seg_done;
   logic               note_end;
   logic [LEN_W-1:0]   mul_a;
   logic [LEVEL_W-1:0] mul_b;
   logic [NUM_W-1:0]   product;
   logic [LEN_W:0]     trial;
   logic [LEN_W:0]     trial_diff;
   logic [USED_W:0]    sus_diff;
   logic               csr_write;
   csr_index_type      csr_index;

   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   // register readback
   always_comb begin
      case (csr_index)
         REG_ATTACK:  csr_prdata = CSR_DATA_W'(attack_ff);
         REG_DECAY:   csr_prdata = CSR_DATA_W'(decay_ff);
         REG_RELEASE: csr_prdata = CSR_DATA_W'(release_ff);
         REG_SUSTAIN: csr_prdata = CSR_DATA_W'(sustain_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // length of the current segment, zero when idle
   always_comb begin
      case (seg_ff)
         SEG_ATTACK:  seg_len = attack_ff;
         SEG_DECAY:   seg_len = decay_ff;
         SEG_SUSTAIN: seg_len = sus_ff;
         SEG_RELEASE: seg_len = release_ff;
         default:     seg_len = '0;
      endcase
   end

   assign seg_done = (seg_ff != SEG_IDLE) && (pos_ff >= seg_len);
   assign note_end = (seg_ff == SEG_IDLE) || (left_ff == '0);

   // one shared multiplier: numerator for the division, then envelope times velocity
   always_comb begin
      if (uword.op == OP_MUL_GAIN) begin
         mul_a = LEN_W'(env_ff);
         mul_b = vel_ff;
      end else if (seg_ff == SEG_RELEASE) begin
         mul_a = seg_len - pos_ff;
         mul_b = sustain_ff;
      end else begin
         mul_a = pos_ff;
         mul_b = GAIN_ONE - sustain_ff;
      end
   end

   assign product = NUM_W'(mul_a) * NUM_W'(mul_b);

   // one restoring division step
   assign trial      = {rem_ff, quo_ff[QUO_W-1]};
   assign trial_diff = trial - {1'b0, div_ff};

   // sustain length: note length minus the other segments, floored at zero
   assign sus_diff = (USED_W+1)'(note_len_ff) - (USED_W+1)'(used_ff);

   // sequencer control
   always_comb begin
      uword = ucode_rom(pc_ff);
      case (uword.hold)
         HOLD_REQ: hold = !req_valid;
         HOLD_RSP: hold = rsp_valid_ff && !rsp_ready;
         default:  hold = 1'b0;
      endcase
      case (uword.jump)
         JMP_ALWAYS:   jump_taken = 1'b1;
         JMP_TICK:     jump_taken = !action_ff;
         JMP_LEN_ZERO: jump_taken = (note_len_ff == '0);
         JMP_SEG_DONE: jump_taken = seg_done;
         JMP_NOTE_END: jump_taken = note_end;
         JMP_SUSTAIN:  jump_taken = (seg_ff == SEG_SUSTAIN);
         JMP_COUNT:    jump_taken = (cnt_ff != '0);
         default:      jump_taken = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      if (hold) begin
         pc_in = pc_ff;
      end else if (jump_taken) begin
         pc_in = uword.target;
      end else begin
         pc_in = step_type'(pc_ff + 4'd1);
      end
   end

   assign req_ready = (pc_ff == STEP_WAIT);

   // datapath actions selected by the control word
   always_comb begin
      attack_in    = attack_ff;
      decay_in     = decay_ff;
      release_in   = release_ff;
      sustain_in   = sustain_ff;
      action_in    = action_ff;
      note_len_in  = note_len_ff;
      note_vel_in  = note_vel_ff;
      seg_in       = seg_ff;
      pos_in       = pos_ff;
      left_in      = left_ff;
      vel_in       = vel_ff;
      sus_in       = sus_ff;
      used_in      = used_ff;
      num_in       = num_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      env_in       = env_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_gain_in  = rsp_gain_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_write) begin
         case (csr_index)
            REG_ATTACK:  attack_in  = csr_pwdata[LEN_W-1:0];
            REG_DECAY:   decay_in   = csr_pwdata[LEN_W-1:0];
            REG_RELEASE: release_in = csr_pwdata[LEN_W-1:0];
            REG_SUSTAIN: sustain_in = sat_level(csr_pwdata[LEVEL_W-1:0]);
            default:     ;
         endcase
      end

      if (!hold) begin
         case (uword.op)
            OP_ACCEPT: begin
               action_in   = req_action;
               note_len_in = req_note_length;
               note_vel_in = req_note_velocity;
            end
            OP_START_A: begin
               used_in = USED_W'(attack_ff) + USED_W'(decay_ff) + USED_W'(release_ff);
               vel_in  = sat_level(note_vel_ff);
               left_in = note_len_ff;
               pos_in  = '0;
               seg_in  = (note_len_ff == '0) ? SEG_IDLE : SEG_ATTACK;
            end
            OP_START_B: begin
               sus_in = sus_diff[USED_W] ? '0 : sus_diff[LEN_W-1:0];
            end
            OP_SKIP: begin
               if (seg_done) begin
                  seg_in = seg_type'(seg_ff + 3'd1);
                  pos_in = '0;
               end
            end
            OP_CHECK: begin
               if (note_end) begin
                  seg_in  = SEG_IDLE;
                  pos_in  = '0;
                  left_in = '0;
               end
            end
            OP_MUL_NUM: begin
               div_in = seg_len;
               num_in = (seg_ff == SEG_ATTACK) ? {1'b0, pos_ff, {FRAC_W{1'b0}}} : product;
            end
            OP_DIV_INIT: begin
               rem_in = num_ff[NUM_W-1:QUO_W];
               quo_in = num_ff[QUO_W-1:0];
               cnt_in = CNT_W'(QUO_W - 1);
            end
            OP_DIV_STEP: begin
               if (!trial_diff[LEN_W]) begin
                  rem_in = trial_diff[LEN_W-1:0];
                  quo_in = {quo_ff[QUO_W-2:0], 1'b1};
               end else begin
                  rem_in = trial[LEN_W-1:0];
                  quo_in = {quo_ff[QUO_W-2:0], 1'b0};
               end
               cnt_in = cnt_ff - CNT_W'(1);
            end
            OP_ENV: begin
               case (seg_ff)
                  SEG_DECAY:   env_in = GAIN_ONE - quo_ff;
                  SEG_SUSTAIN: env_in = sustain_ff;
                  default:     env_in = quo_ff;
               endcase
            end
            OP_MUL_GAIN: begin
               num_in = product;
            end
            OP_EMIT: begin
               rsp_valid_in = 1'b1;
               rsp_gain_in  = num_ff[FRAC_W+LEVEL_W-1:FRAC_W];
               rsp_seg_in   = seg_ff[1:0];
               rsp_last_in  = (left_ff == LEN_W'(1));
               left_in      = left_ff - LEN_W'(1);
               if (left_ff == LEN_W'(1)) begin
                  seg_in = SEG_IDLE;
                  pos_in = '0;
               end else begin
                  pos_in = pos_ff + LEN_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_WAIT;
         attack_ff    <= ATTACK_RESET;
         decay_ff     <= DECAY_RESET;
         release_ff   <= RELEASE_RESET;
         sustain_ff   <= SUSTAIN_RESET;
         seg_ff       <= SEG_IDLE;
         pos_ff       <= '0;
         left_ff      <= '0;
         vel_ff       <= '0;
         sus_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         attack_ff    <= attack_in;
         decay_ff     <= decay_in;
         release_ff   <= release_in;
         sustain_ff   <= sustain_in;
         seg_ff       <= seg_in;
         pos_ff       <= pos_in;
         left_ff      <= left_in;
         vel_ff       <= vel_in;
         sus_ff       <= sus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      note_len_ff <= note_len_in;
      note_vel_ff <= note_vel_in;
      used_ff     <= used_in;
      num_ff      <= num_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      env_ff      <= env_in;
      rsp_gain_ff <= rsp_gain_in;
      rsp_seg_ff  <= rsp_seg_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_gain    = rsp_gain_ff;
   assign rsp_segment = rsp_seg_ff;
   assign rsp_last    = rsp_last_ff;

endmodule
